[rtl/kpp_pkg.sv]
// Shared widths, codes, stage payload and helpers for the keyframe pair and phase block.
package kpp_pkg;

  localparam int KPP_TIME_W     = 32;
  localparam int KPP_FPS_W      = 16;
  localparam int KPP_LEN_W      = 12;
  localparam int KPP_MOD_W      = KPP_LEN_W + 1;
  localparam int KPP_PROD_W     = KPP_TIME_W + KPP_FPS_W;
  localparam int KPP_FRAC_W     = 16;
  localparam int KPP_RATE_FRAC  = 8;
  localparam int KPP_IDX_W      = KPP_PROD_W - KPP_RATE_FRAC - KPP_FRAC_W;
  localparam int KPP_PHASE_W    = KPP_FRAC_W + 1;
  localparam int KPP_DIGITS     = 8;
  localparam int KPP_MODE_W     = 2;
  localparam int KPP_CFG_IDX_W  = 2;
  localparam int KPP_CFG_DATA_W = 16;
  localparam int KPP_TDATA_W    = 48;

  localparam logic [KPP_PHASE_W-1:0] KPP_PHASE_ONE = KPP_PHASE_W'(1 << KPP_FRAC_W);

  localparam logic [KPP_MODE_W-1:0] MODE_LOOP   = 2'd0;
  localparam logic [KPP_MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [KPP_MODE_W-1:0] MODE_MIRROR = 2'd2;

  localparam logic [KPP_CFG_IDX_W-1:0] REG_PLAY_MODE = 2'd0;
  localparam logic [KPP_CFG_IDX_W-1:0] REG_INTERVALS = 2'd1;
  localparam logic [KPP_CFG_IDX_W-1:0] REG_FPS       = 2'd2;

  // Work item between the split stage and the output stage.
  typedef struct packed {
    logic                  neg;    // whole frame count was negative
    logic [KPP_IDX_W-1:0]  dvd;    // magnitude bits still to be reduced, top first
    logic [KPP_MOD_W-1:0]  rem;    // partial remainder
    logic [KPP_FRAC_W-1:0] frac;   // fractional frame position
    logic [KPP_IDX_W-1:0]  n;      // signed whole frame count
  } kpp_work_t;

  // Wrap length in whole frames: twice the track for mirror mode.
  function automatic logic [KPP_MOD_W-1:0] kpp_modulus(logic [KPP_MODE_W-1:0] mode,
                                                       logic [KPP_LEN_W-1:0]  len);
    kpp_modulus = (mode == MODE_MIRROR) ? {len, 1'b0} : {1'b0, len};
  endfunction

endpackage

[rtl/keyframe_pair_and_phase.sv]
// Keyframe pair and phase lookup: top level with configuration registers and pipeline.
//
// Input stream s_*: one signed Q15.16 playback time per transfer.
// Output stream m_*: first and second keyframe index and the Q1.16 phase in
//   m_tdata, the degenerate flag (zero length or zero rate) in m_tuser.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   index 0 play mode, 1 interval count, 2 rate in Q8.8. Write only while idle.
// Pipeline: rate multiply, position split, three remainder stages of eight
//   bits each and the output register: six register stages. One item per
//   cycle is taken as long as the receiver keeps m_tready high.
// Stall: each stage holds while the one after it is full and stalled; empty
//   stages keep filling, so s_tready drops only once every stage holds an item.
// Reset (rst, synchronous): empties the pipeline and sets loop mode, zero
//   intervals and a rate of one frame per second.
module keyframe_pair_and_phase import kpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [KPP_TIME_W-1:0]     s_tdata,   // [31:0] play_time
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [KPP_TDATA_W-1:0]    m_tdata,   // [11:0] first_frame, [23:12] second_frame,
                                               // [40:24] phase, [47:41] zero
  output logic                      m_tuser,   // [0] degenerate
  input  logic                      cfg_we,
  input  logic [KPP_CFG_IDX_W-1:0]  cfg_index,
  input  logic [KPP_CFG_DATA_W-1:0] cfg_data
);

  logic [KPP_MODE_W-1:0]  play_mode;
  logic [KPP_LEN_W-1:0]   frame_intervals;
  logic [KPP_FPS_W-1:0]   frames_per_second;
  logic [KPP_MOD_W-1:0]   modulus;

  logic                   v0, v1, v2, v3;
  logic                   r0, r1, r2, r3;
  kpp_work_t              w0, w1, w2, w3;

  logic [KPP_LEN_W-1:0]   first_frame;
  logic [KPP_LEN_W-1:0]   second_frame;
  logic [KPP_PHASE_W-1:0] phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode         <= MODE_LOOP;
      frame_intervals   <= '0;
      frames_per_second <= KPP_FPS_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAY_MODE: play_mode         <= cfg_data[KPP_MODE_W-1:0];
        REG_INTERVALS: frame_intervals   <= cfg_data[KPP_LEN_W-1:0];
        REG_FPS:       frames_per_second <= cfg_data[KPP_FPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign modulus = kpp_modulus(play_mode, frame_intervals);

  kpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_time   (s_tdata),
    .fps       (frames_per_second),
    .out_valid (v0),
    .out_ready (r0),
    .out_work  (w0)
  );

  kpp_mod_stage u_mod0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (r0),
    .in_work   (w0),
    .modulus   (modulus),
    .out_valid (v1),
    .out_ready (r1),
    .out_work  (w1)
  );

  kpp_mod_stage u_mod1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_work   (w1),
    .modulus   (modulus),
    .out_valid (v2),
    .out_ready (r2),
    .out_work  (w2)
  );

  kpp_mod_stage u_mod2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_work   (w2),
    .modulus   (modulus),
    .out_valid (v3),
    .out_ready (r3),
    .out_work  (w3)
  );

  kpp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (v3),
    .in_ready     (r3),
    .in_work      (w3),
    .mode         (play_mode),
    .len          (frame_intervals),
    .fps          (frames_per_second),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .first_frame  (first_frame),
    .second_frame (second_frame),
    .phase        (phase),
    .degenerate   (m_tuser)
  );

  assign m_tdata = {{(KPP_TDATA_W - 2*KPP_LEN_W - KPP_PHASE_W){1'b0}},
                    phase, second_frame, first_frame};

endmodule

[rtl/kpp_front.sv]
// Rate multiply stage and frame position split stage.
module kpp_front import kpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KPP_TIME_W-1:0] in_time,
  input  logic [KPP_FPS_W-1:0]  fps,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kpp_work_t             out_work
);

  logic                  prod_valid;
  logic [KPP_PROD_W-1:0] prod;
  logic [KPP_PROD_W-1:0] prod_next;
  logic                  split_ready;
  logic [KPP_IDX_W-1:0]  n;
  logic [KPP_IDX_W-1:0]  mag;
  kpp_work_t             work_next;

  // Low product bits are exact in two's complement.
  assign prod_next = {{KPP_FPS_W{in_time[KPP_TIME_W-1]}}, in_time}
                   * {{KPP_TIME_W{1'b0}}, fps};

  assign split_ready = !out_valid || out_ready;
  assign in_ready    = !prod_valid || split_ready;

  // Floor of product / 256 is an arithmetic shift; whole frames sit above the fraction.
  assign n   = prod[KPP_PROD_W-1 -: KPP_IDX_W];
  assign mag = n[KPP_IDX_W-1] ? (~n + KPP_IDX_W'(1)) : n;

  always_comb begin
    work_next      = '0;
    work_next.neg  = n[KPP_IDX_W-1];
    work_next.dvd  = mag;
    work_next.rem  = '0;
    work_next.frac = prod[KPP_RATE_FRAC +: KPP_FRAC_W];
    work_next.n    = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        prod_valid <= in_valid;
      end
      if (split_ready) begin
        out_valid <= prod_valid;
      end
    end
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
    if (split_ready && prod_valid) begin
      out_work <= work_next;
    end
  end

endmodule

[rtl/kpp_mod_stage.sv]
// One pipeline stage of the restoring remainder: eight dividend bits per stage.
module kpp_mod_stage import kpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kpp_work_t             in_work,
  input  logic [KPP_MOD_W-1:0]  modulus,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kpp_work_t             out_work
);

  kpp_work_t work_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic [KPP_MOD_W:0]   trial;
    logic [KPP_MOD_W-1:0] r;
    logic [KPP_IDX_W-1:0] d;
    r = in_work.rem;
    d = in_work.dvd;
    for (int i = 0; i < KPP_DIGITS; i++) begin
      trial = {r, d[KPP_IDX_W-1]};
      d     = {d[KPP_IDX_W-2:0], 1'b0};
      if (trial >= {1'b0, modulus}) begin
        trial = trial - {1'b0, modulus};
      end
      r = trial[KPP_MOD_W-1:0];
    end
    work_next     = in_work;
    work_next.rem = r;
    work_next.dvd = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

[rtl/kpp_out.sv]
// Output stage: sign fix of the remainder, mode select, mirror fold, result register.
module kpp_out import kpp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  kpp_work_t              in_work,
  input  logic [KPP_MODE_W-1:0]  mode,
  input  logic [KPP_LEN_W-1:0]   len,
  input  logic [KPP_FPS_W-1:0]   fps,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KPP_LEN_W-1:0]   first_frame,
  output logic [KPP_LEN_W-1:0]   second_frame,
  output logic [KPP_PHASE_W-1:0] phase,
  output logic                   degenerate
);

  logic [KPP_MOD_W-1:0]   m;
  logic [KPP_MOD_W-1:0]   r;
  logic [KPP_MOD_W-1:0]   r_up;
  logic [KPP_MOD_W-1:0]   len2;
  logic [KPP_MOD_W-1:0]   fold_a;
  logic [KPP_MOD_W-1:0]   fold_b;
  logic [KPP_LEN_W-1:0]   first_next;
  logic [KPP_LEN_W-1:0]   second_next;
  logic [KPP_PHASE_W-1:0] phase_next;
  logic                   degen_next;

  assign in_ready = !out_valid || out_ready;

  assign m    = kpp_modulus(mode, len);
  // Floor modulo: a negative count with a nonzero remainder wraps up from the modulus.
  assign r    = (in_work.neg && (in_work.rem != '0)) ? (m - in_work.rem) : in_work.rem;
  assign r_up = r + KPP_MOD_W'(1);
  assign len2 = {len, 1'b0};

  assign fold_a = (r    > {1'b0, len}) ? (len2 - r)    : r;
  assign fold_b = (r_up > {1'b0, len}) ? (len2 - r_up) : r_up;

  always_comb begin
    first_next  = r[KPP_LEN_W-1:0];
    second_next = r_up[KPP_LEN_W-1:0];
    phase_next  = {1'b0, in_work.frac};
    degen_next  = 1'b0;
    case (mode)
      MODE_SINGLE: begin
        if (in_work.n[KPP_IDX_W-1]) begin
          first_next  = '0;
          second_next = KPP_LEN_W'(1);
          phase_next  = '0;
        end else if (in_work.n >= {{(KPP_IDX_W-KPP_LEN_W){1'b0}}, len}) begin
          first_next  = len - KPP_LEN_W'(1);
          second_next = len;
          phase_next  = KPP_PHASE_ONE;
        end else begin
          first_next  = in_work.n[KPP_LEN_W-1:0];
          second_next = in_work.n[KPP_LEN_W-1:0] + KPP_LEN_W'(1);
        end
      end
      MODE_MIRROR: begin
        first_next  = fold_a[KPP_LEN_W-1:0];
        second_next = fold_b[KPP_LEN_W-1:0];
      end
      default: begin
      end
    endcase
    if (len == '0 || fps == '0) begin
      first_next  = '0;
      second_next = '0;
      phase_next  = '0;
      degen_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      first_frame  <= first_next;
      second_frame <= second_next;
      phase        <= phase_next;
      degenerate   <= degen_next;
    end
  end

endmodule

[rtl/kpp_checker.sv]
// Port-level checks on the result stream, bound to the top level.
module kpp_checker import kpp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [KPP_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser
);

  logic [KPP_LEN_W-1:0]   first_frame;
  logic [KPP_LEN_W-1:0]   second_frame;
  logic [KPP_PHASE_W-1:0] phase;

  assign first_frame  = m_tdata[KPP_LEN_W-1:0];
  assign second_frame = m_tdata[2*KPP_LEN_W-1:KPP_LEN_W];
  assign phase        = m_tdata[2*KPP_LEN_W +: KPP_PHASE_W];

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A degenerate result carries all-zero fields.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("degenerate result with nonzero fields");

  // Phase never exceeds one, and full weight only at the clamped end of the track.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (phase <= KPP_PHASE_ONE))
    else $error("phase above one");

  a_end_pair: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (phase == KPP_PHASE_ONE)) |-> (second_frame == first_frame + KPP_LEN_W'(1)))
    else $error("clamped end with non-adjacent keyframes");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind keyframe_pair_and_phase kpp_checker u_kpp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/tb_keyframe_pair_and_phase.sv]
// Self-checking testbench for the keyframe pair and phase lookup block.
module tb_keyframe_pair_and_phase;
  import kpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KPP_MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [KPP_CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 10;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 68;

  typedef struct packed {
    logic [KPP_LEN_W-1:0]   first;
    logic [KPP_LEN_W-1:0]   second;
    logic [KPP_PHASE_W-1:0] phase;
    logic                   degen;
  } frame_pick_t;

  // One directed cue: raw register values, play time, and an optional hand-typed answer.
  typedef struct packed {
    logic [15:0]            mode_raw;
    logic [15:0]            len_raw;
    logic [15:0]            fps_raw;
    logic [KPP_TIME_W-1:0]  play_time;
    logic                   typed;
    logic [KPP_LEN_W-1:0]   first;
    logic [KPP_LEN_W-1:0]   second;
    logic [KPP_PHASE_W-1:0] phase;
    logic                   degen;
  } cue_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [KPP_TIME_W-1:0]     s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [KPP_TDATA_W-1:0]    m_tdata;
  logic                      m_tuser;
  logic                      cfg_we = 1'b0;
  logic [KPP_CFG_IDX_W-1:0]  cfg_index = '0;
  logic [KPP_CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadow, as the block holds it after masking.
  logic [KPP_MODE_W-1:0] cur_mode = MODE_LOOP;
  logic [KPP_LEN_W-1:0]  cur_len  = '0;
  logic [KPP_FPS_W-1:0]  cur_fps  = 16'd256;
  logic [47:0]           last_raw;

  frame_pick_t pending_picks[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_ask = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_degen = 0;
  int n_clamped = 0;
  int n_settings = 0;

  cue_t cues [25] = '{
    '{16'(MODE_LOOP),   16'd0,     16'd256,   32'h7FFF_FFFF, 1'b1, 12'd0, 12'd0,  17'd0,     1'b1},
    '{16'(MODE_LOOP),   16'd0,     16'd256,   32'h8000_0000, 1'b1, 12'd0, 12'd0,  17'd0,     1'b1},
    '{16'(MODE_LOOP),   16'd10,    16'd256,   32'h0000_0000, 1'b1, 12'd0, 12'd1,  17'd0,     1'b0},
    '{16'(MODE_LOOP),   16'd10,    16'd256,   32'h0001_0000, 1'b1, 12'd1, 12'd2,  17'd0,     1'b0},
    '{16'(MODE_LOOP),   16'd10,    16'd256,   32'hFFFF_FFFF, 1'b1, 12'd9, 12'd10, 17'd65535, 1'b0},
    '{16'(MODE_LOOP),   16'd10,    16'd256,   32'h000A_0000, 1'b1, 12'd0, 12'd1,  17'd0,     1'b0},
    '{16'(MODE_LOOP),   16'd10,    16'd0,     32'h0003_0000, 1'b1, 12'd0, 12'd0,  17'd0,     1'b1},
    '{16'(MODE_SINGLE), 16'd10,    16'd256,   32'hFFFB_0000, 1'b1, 12'd0, 12'd1,  17'd0,     1'b0},
    '{16'(MODE_SINGLE), 16'd10,    16'd256,   32'h000A_0000, 1'b1, 12'd9, 12'd10, 17'd65536, 1'b0},
    '{16'(MODE_SINGLE), 16'd10,    16'd256,   32'h7FFF_FFFF, 1'b1, 12'd9, 12'd10, 17'd65536, 1'b0},
    '{16'(MODE_SINGLE), 16'd10,    16'd256,   32'h0009_8000, 1'b1, 12'd9, 12'd10, 17'd32768, 1'b0},
    '{16'(MODE_MIRROR), 16'd10,    16'd256,   32'h000A_0000, 1'b1, 12'd10, 12'd9, 17'd0,     1'b0},
    '{16'(MODE_MIRROR), 16'd10,    16'd256,   32'h000F_4000, 1'b1, 12'd5, 12'd4,  17'd16384, 1'b0},
    '{16'(MODE_MIRROR), 16'd10,    16'd256,   32'hFFFF_C000, 1'b1, 12'd1, 12'd0,  17'd49152, 1'b0},
    '{16'(MODE_MIRROR), 16'd10,    16'd256,   32'h0013_8000, 1'b1, 12'd1, 12'd0,  17'd32768, 1'b0},
    // upper bits of the write data must be dropped
    '{{14'h3FFF, MODE_MIRROR}, 16'hF00A, 16'd65535, 32'h8000_0000, 1'b0, 12'd0, 12'd0, 17'd0, 1'b0},
    '{{14'h3FFF, MODE_MIRROR}, 16'hF00A, 16'd65535, 32'h7FFF_FFFF, 1'b0, 12'd0, 12'd0, 17'd0, 1'b0},
    '{16'(MODE_SPARE),  16'd4095,  16'd65535, 32'h7FFF_FFFF, 1'b0, 12'd0, 12'd0,  17'd0,     1'b0},
    '{16'(MODE_SPARE),  16'd4095,  16'd65535, 32'h8000_0000, 1'b0, 12'd0, 12'd0,  17'd0,     1'b0},
    '{16'(MODE_SINGLE), 16'd1,     16'd1,     32'h7FFF_FFFF, 1'b1, 12'd0, 12'd1,  17'd65536, 1'b0},
    '{16'(MODE_SINGLE), 16'd1,     16'd1,     32'h8000_0000, 1'b1, 12'd0, 12'd1,  17'd0,     1'b0},
    '{16'(MODE_MIRROR), 16'd4095,  16'd65535, 32'h1234_5678, 1'b0, 12'd0, 12'd0,  17'd0,     1'b0},
    '{16'(MODE_LOOP),   16'd4095,  16'd1,     32'h0000_00FF, 1'b1, 12'd0, 12'd1,  17'd0,     1'b0},
    '{16'(MODE_LOOP),   16'd1,     16'd256,   32'h0000_0001, 1'b1, 12'd0, 12'd1,  17'd1,     1'b0},
    // interval count masks to zero
    '{16'(MODE_LOOP),   16'h1000,  16'd256,   32'h0001_0000, 1'b1, 12'd0, 12'd0,  17'd0,     1'b1}
  };

  keyframe_pair_and_phase i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [31:0] play_time
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [11:0] first_frame, [23:12] second_frame, [40:24] phase
    .m_tuser   (m_tuser),    // [0] degenerate
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic frame_pick_t pick_frames(logic [KPP_TIME_W-1:0] t,
                                              logic [KPP_MODE_W-1:0] mode,
                                              logic [KPP_LEN_W-1:0]  len,
                                              logic [KPP_FPS_W-1:0]  fps);
    frame_pick_t p;
    longint tt, rate, ln, pos, lenq, wrap, r, a, b;
    p = '0;
    if (len == 0 || fps == 0) begin
      p.degen = 1'b1;
      return p;
    end
    tt   = longint'($signed(t));
    rate = longint'(fps);
    ln   = longint'(len);
    pos  = (tt * rate) >>> KPP_RATE_FRAC;   // floor of time * rate
    lenq = ln << KPP_FRAC_W;
    if (mode == MODE_SINGLE) begin
      if (pos < 0) pos = 0;
      if (pos > lenq) pos = lenq;
      a = pos >>> KPP_FRAC_W;
      if (a >= ln) begin
        p.first  = len - 1'b1;
        p.second = len;
        p.phase  = KPP_PHASE_ONE;
      end else begin
        p.first  = a[KPP_LEN_W-1:0];
        p.second = p.first + 1'b1;
        p.phase  = {1'b0, pos[KPP_FRAC_W-1:0]};
      end
    end else begin
      wrap = (mode == MODE_MIRROR) ? 2 * lenq : lenq;
      r = pos % wrap;
      if (r < 0) r += wrap;
      a = r >>> KPP_FRAC_W;
      b = a + 1;
      // fold indices past the track end back toward the start
      if (mode == MODE_MIRROR) begin
        if (a > ln) a = 2 * ln - a;
        if (b > ln) b = 2 * ln - b;
      end
      p.first  = a[KPP_LEN_W-1:0];
      p.second = b[KPP_LEN_W-1:0];
      p.phase  = {1'b0, r[KPP_FRAC_W-1:0]};
    end
    return p;
  endfunction

  function automatic logic [KPP_TIME_W-1:0] rand_play_time();
    logic [KPP_TIME_W-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;   // within about 16 s of zero
      3: v = ($urandom_range(0, 63) << KPP_FRAC_W) - 32'h0020_0000 + $urandom_range(0, 2) - 1;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  // Offer one play time, wait for its transfer, and queue what it must produce.
  task automatic send_time(input logic [KPP_TIME_W-1:0] t, input logic typed,
                           input frame_pick_t typed_pick);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    pending_picks.push_back(typed ? typed_pick : pick_frames(t, cur_mode, cur_len, cur_fps));
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Reprogram all three registers while the pipeline is empty.
  task automatic set_track(input logic [15:0] mode_raw, input logic [15:0] len_raw,
                           input logic [15:0] fps_raw);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PLAY_MODE;
    cfg_data  <= mode_raw;
    @(negedge clk);
    cfg_index <= REG_INTERVALS;
    cfg_data  <= len_raw;
    @(negedge clk);
    cfg_index <= REG_FPS;
    cfg_data  <= fps_raw;
    @(negedge clk);
    // nothing lives at this index; the write must leave every register alone
    cfg_index <= REG_SPARE;
    cfg_data  <= 16'($urandom());
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode_raw[KPP_MODE_W-1:0];
    cur_len  = len_raw[KPP_LEN_W-1:0];
    cur_fps  = fps_raw;
    last_raw = {mode_raw, len_raw, fps_raw};
    n_settings++;
  endtask

  always @(negedge clk) begin
    if (hold_ask && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_pick_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.first  = m_tdata[KPP_LEN_W-1:0];
      got.second = m_tdata[2*KPP_LEN_W-1:KPP_LEN_W];
      got.phase  = m_tdata[2*KPP_LEN_W +: KPP_PHASE_W];
      got.degen  = m_tuser;
      if (pending_picks.size() == 0) begin
        $display("%0t ns: result with nothing expected, got %0d %0d %0d %0b", $time,
                 got.first, got.second, got.phase, got.degen);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        if (got.first !== want.first)
          report("first_frame", 32'(want.first), 32'(got.first));
        if (got.second !== want.second)
          report("second_frame", 32'(want.second), 32'(got.second));
        if (got.phase !== want.phase)
          report("phase", 32'(want.phase), 32'(got.phase));
        if (got.degen !== want.degen)
          report("degenerate", 32'(want.degen), 32'(got.degen));
        n_checked++;
        if (want.degen) n_degen++;
        if (want.phase == KPP_PHASE_ONE) n_clamped++;
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding", $time,
               QUIET_LIMIT, pending_picks.size());
      $display("tb_keyframe_pair_and_phase: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [KPP_MODE_W-1:0] mode;
    logic [KPP_LEN_W-1:0]  len;
    logic [KPP_FPS_W-1:0]  fps;
    frame_pick_t           typed_pick;
    last_raw = {16'(MODE_LOOP), 16'd0, 16'd256};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (cues[i]) begin
      if ({cues[i].mode_raw, cues[i].len_raw, cues[i].fps_raw} != last_raw)
        set_track(cues[i].mode_raw, cues[i].len_raw, cues[i].fps_raw);
      typed_pick = '{cues[i].first, cues[i].second, cues[i].phase, cues[i].degen};
      send_time(cues[i].play_time, cues[i].typed, typed_pick);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mode = MODE_LOOP;   len = 12'd4095; fps = 16'd65535; end
        1: begin mode = MODE_SINGLE; len = 12'd1;    fps = 16'd1;     end
        2: begin mode = MODE_MIRROR; len = 12'd1;    fps = 16'd256;   end
        3: begin mode = MODE_SPARE;  len = 12'd7;    fps = 16'd384;   end
        4: begin
          mode = MODE_SINGLE;
          len  = 12'($urandom_range(1, 40));
          fps  = 16'($urandom_range(1, 65535));
        end
        5: begin mode = MODE_MIRROR; len = 12'd4095; fps = 16'd1;     end
        6: begin mode = MODE_LOOP;   len = 12'd1;    fps = 16'd65535; end
        default: begin
          mode = 2'($urandom_range(0, 3));
          len  = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(1, 64));
          fps  = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        end
      endcase
      set_track({14'($urandom()), mode}, {4'($urandom()), len}, fps);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // long receiver hold while the sender keeps offering, to fill the pipeline
      if (p == 4) hold_ask = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_time(rand_play_time(), 1'b0, '0);
    end

    drain();
    $display("Sent %0d play times over %0d register settings; checked %0d results,",
             n_items, n_settings, n_checked);
    $display("%0d of them degenerate and %0d clamped at the track end.", n_degen, n_clamped);
    if (errors == 0 && pending_picks.size() == 0) begin
      $display("tb_keyframe_pair_and_phase: clean");
    end else begin
      $display("tb_keyframe_pair_and_phase: errors");
    end
    $finish;
  end

endmodule
